FILE: hdl/g711_pkg.sv
// ---------------------------------------------------------------------------
// g711_pkg
// Shared types and constants for the G.711 A-law / mu-law companding codec.
// ---------------------------------------------------------------------------
package g711_pkg;

   // Conversion selector carried in the request tuser field
   typedef enum logic [1:0] {
      MODE_ALAW_ENC = 2'd0,
      MODE_ALAW_DEC = 2'd1,
      MODE_ULAW_ENC = 2'd2,
      MODE_ULAW_DEC = 2'd3
   } mode_type;

   // One request as held in the input register
   typedef struct packed {
      mode_type           mode;
      logic signed [15:0] pcm_in;
      logic [7:0]         code_in;
   } req_type;

   // Transmission inversion masks
   localparam logic [7:0] ALAW_MASK_POS = 8'hD5;
   localparam logic [7:0] ALAW_MASK_NEG = 8'h55;
   localparam logic [7:0] ULAW_MASK_POS = 8'hFF;
   localparam logic [7:0] ULAW_MASK_NEG = 8'h7F;
   localparam logic [7:0] MAX_MAG_CODE  = 8'h7F;

   // mu-law magnitude clip, bias (on the scaled-by-4 magnitude) and decoder bias
   localparam logic [13:0] ULAW_CLIP     = 14'd8159;
   localparam logic [13:0] ULAW_ENC_BIAS = 14'd33;
   localparam logic [15:0] ULAW_DEC_BIAS = 16'h0084;

   // A-law decoder offsets
   localparam logic [15:0] ALAW_DEC_BIAS = 16'h0108;
   localparam logic [15:0] ALAW_SEG0_OFS = 16'h0008;

endpackage

FILE: hdl/g711_enc.sv
// ---------------------------------------------------------------------------
// g711_enc
// Linear PCM to companded byte, A-law or mu-law, purely combinational.
// ---------------------------------------------------------------------------
module g711_enc (
   input  logic               ulaw_sel,
   input  logic signed [15:0] pcm_in,
   output logic [7:0]         code_out
);

   logic        neg;
   logic [15:0] pcm_inv;
   logic [11:0] a_mag;
   logic [2:0]  a_seg;
   logic [11:0] a_shift;
   logic [3:0]  a_q;
   logic [7:0]  a_mask;
   logic [7:0]  a_code;
   logic [13:0] u_raw;
   logic [13:0] u_clip;
   logic [13:0] u_bias;
   logic [2:0]  u_seg;
   logic [13:0] u_shift;
   logic [3:0]  u_q;
   logic [7:0]  u_mask;
   logic [7:0]  u_code;

   assign neg     = pcm_in[15];
   assign pcm_inv = ~pcm_in;

   // A-law: magnitude scaled by 8, one's complement for negative samples
   assign a_mag = neg ? pcm_inv[14:3] : pcm_in[14:3];

   // segment = highest set bit above the first segment
   always_comb begin
      a_seg = 3'd0;
      for (int i = 5; i < 12; i++) begin
         if (a_mag[i]) begin
            a_seg = 3'(i - 4);
         end
      end
   end

   assign a_shift = a_mag >> a_seg;
   assign a_q     = (a_seg < 3'd2) ? a_mag[4:1] : a_shift[3:0];
   assign a_mask  = neg ? g711_pkg::ALAW_MASK_NEG : g711_pkg::ALAW_MASK_POS;
   assign a_code  = {1'b0, a_seg, a_q} ^ a_mask;

   // mu-law: magnitude scaled by 4, clipped, then biased
   assign u_raw  = neg ? ({1'b0, pcm_inv[14:2]} + 14'd1) : {1'b0, pcm_in[14:2]};
   assign u_clip = (u_raw > g711_pkg::ULAW_CLIP) ? g711_pkg::ULAW_CLIP : u_raw;
   assign u_bias = u_clip + g711_pkg::ULAW_ENC_BIAS;

   always_comb begin
      u_seg = 3'd0;
      for (int i = 6; i < 13; i++) begin
         if (u_bias[i]) begin
            u_seg = 3'(i - 5);
         end
      end
   end

   assign u_shift = u_bias >> ({1'b0, u_seg} + 4'd1);
   assign u_q     = u_shift[3:0];
   assign u_mask  = neg ? g711_pkg::ULAW_MASK_NEG : g711_pkg::ULAW_MASK_POS;

   // bit 13 set means the biased magnitude passed the top segment
   assign u_code = u_bias[13] ? (g711_pkg::MAX_MAG_CODE ^ u_mask)
                              : ({1'b0, u_seg, u_q} ^ u_mask);

   assign code_out = ulaw_sel ? u_code : a_code;

endmodule

FILE: hdl/g711_dec.sv
// ---------------------------------------------------------------------------
// g711_dec
// Companded byte to linear PCM, A-law or mu-law, purely combinational.
// ---------------------------------------------------------------------------
module g711_dec (
   input  logic               ulaw_sel,
   input  logic [7:0]         code_in,
   output logic signed [15:0] pcm_out
);

   logic [7:0]  a_code;
   logic [2:0]  a_seg;
   logic [15:0] a_base;
   logic [15:0] a_mag;
   logic [15:0] a_pcm;
   logic [7:0]  u_code;
   logic [15:0] u_mag;
   logic [15:0] u_pcm;

   // A-law: undo even-bit inversion, rebuild the segment value
   assign a_code = code_in ^ g711_pkg::ALAW_MASK_NEG;
   assign a_seg  = a_code[6:4];
   assign a_base = {8'd0, a_code[3:0], 4'd0};
   assign a_mag  = (a_seg == 3'd0) ? (a_base + g711_pkg::ALAW_SEG0_OFS)
                                   : ((a_base + g711_pkg::ALAW_DEC_BIAS) << (a_seg - 3'd1));
   assign a_pcm  = a_code[7] ? a_mag : (16'd0 - a_mag);

   // mu-law: full complement, biased mantissa shifted by the segment
   assign u_code = ~code_in;
   assign u_mag  = ({9'd0, u_code[3:0], 3'd0} + g711_pkg::ULAW_DEC_BIAS) << u_code[6:4];
   assign u_pcm  = u_code[7] ? (g711_pkg::ULAW_DEC_BIAS - u_mag)
                             : (u_mag - g711_pkg::ULAW_DEC_BIAS);

   assign pcm_out = ulaw_sel ? u_pcm : a_pcm;

endmodule

FILE: hdl/g711_companding_codec.sv
// ---------------------------------------------------------------------------
// g711_companding_codec
// G.711 A-law / mu-law encoder and decoder on a pair of stream channels.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on req_*: tuser selects the conversion (0 A-law encode,
//   1 A-law decode, 2 mu-law encode, 3 mu-law decode), tdata carries the PCM
//   sample and the companded byte. Each request gives exactly one response on
//   rsp_*, carrying the companded byte and the PCM sample; the field the
//   conversion does not produce reads zero.
//   A request taken on req_* passes the input register, then the result
//   register, before rsp_tvalid shows it. Throughput is one request per cycle
//   unless rsp_tready stalls, set by the single combinational pass between
//   the two registers. Backpressure: when rsp_tready is low the result
//   register holds; the input register still takes one more request, then
//   req_tready drops. Reset clears both valid flags; no request is lost or
//   repeated across a stall. The block keeps no state between requests.
// ---------------------------------------------------------------------------
module g711_companding_codec (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic [23:0] req_tdata,   // [15:0] pcm_in, [23:16] code_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] code_out, [23:8] pcm_out
);

   logic                in_vld_ff;
   logic                in_vld_in;
   g711_pkg::req_type   in_req_ff;
   logic                out_vld_ff;
   logic                out_vld_in;
   logic [7:0]          out_code_ff;
   logic [7:0]          out_code_in;
   logic signed [15:0]  out_pcm_ff;
   logic signed [15:0]  out_pcm_in;
   logic                out_load;
   logic                in_load;
   logic                ulaw_sel;
   logic [7:0]          enc_code;
   logic signed [15:0]  dec_pcm;

   // Handshake: result register frees when empty or drained
   assign out_load   = !out_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || out_load;
   assign in_load    = req_tvalid && req_tready;

   assign in_vld_in  = in_load || (in_vld_ff && !out_load);
   assign out_vld_in = out_load ? in_vld_ff : out_vld_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_req_ff.mode    <= g711_pkg::mode_type'(req_tuser);
         in_req_ff.pcm_in  <= req_tdata[15:0];
         in_req_ff.code_in <= req_tdata[23:16];
      end
   end

   // Conversion units
   assign ulaw_sel = in_req_ff.mode[1];

   g711_enc u_enc (
      .ulaw_sel (ulaw_sel),
      .pcm_in   (in_req_ff.pcm_in),
      .code_out (enc_code)
   );

   g711_dec u_dec (
      .ulaw_sel (ulaw_sel),
      .code_in  (in_req_ff.code_in),
      .pcm_out  (dec_pcm)
   );

   // Result select: unused field reads zero
   always_comb begin
      unique case (in_req_ff.mode)
         g711_pkg::MODE_ALAW_ENC,
         g711_pkg::MODE_ULAW_ENC: begin
            out_code_in = enc_code;
            out_pcm_in  = 16'sd0;
         end
         g711_pkg::MODE_ALAW_DEC,
         g711_pkg::MODE_ULAW_DEC: begin
            out_code_in = 8'd0;
            out_pcm_in  = dec_pcm;
         end
         default: begin
            out_code_in = 8'd0;
            out_pcm_in  = 16'sd0;
         end
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && in_vld_ff) begin
         out_code_ff <= out_code_in;
         out_pcm_ff  <= out_pcm_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_pcm_ff, out_code_ff};

endmodule
